FILE: rtl/gncf_pkg.sv
package gncf_pkg;

    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;

    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int THR_W       = 4;
    localparam int CELL_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int STEP_W      = 4;

    localparam logic signed [CELL_W-1:0] CELL_UNKNOWN  = -8'sd1;
    localparam logic signed [CELL_W-1:0] CELL_OCCUPIED = 8'sd100;
    localparam logic [COUNT_W-1:0]       COUNT_UNKNOWN = 4'd10;
    localparam logic [COUNT_W-1:0]       COUNT_MAX_OCC = 4'd8;

    localparam logic [CFG_W-1:0] RESET_GRID_DIM  = 9'd256;
    localparam logic [THR_W-1:0] RESET_THRESHOLD = 4'd4;

    // Window steps run in raster order over the 3x3 window; the center is step 4.
    localparam logic [STEP_W-1:0] STEP_FIRST  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CENTER = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH     = 2'd0,
        REG_GRID_HEIGHT    = 2'd1,
        REG_PASS_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        OFS_MINUS = 2'd0,
        OFS_ZERO  = 2'd1,
        OFS_PLUS  = 2'd2
    } ofs_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SIZE   = 3'd1,
        ST_LOAD   = 3'd2,
        ST_SETUP  = 3'd3,
        ST_READ   = 3'd4,
        ST_DRAIN  = 3'd5,
        ST_FINISH = 3'd6
    } state_t;

    typedef struct packed {
        logic              take;
        logic              load_write;
        logic              setup;
        logic              rd_en;
        logic [STEP_W-1:0] rd_step;
        logic              finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic ofs_t step_row_ofs(input logic [STEP_W-1:0] step);
        ofs_t ofs;
        if (step < 4'd3)
            ofs = OFS_MINUS;
        else if (step < 4'd6)
            ofs = OFS_ZERO;
        else
            ofs = OFS_PLUS;
        return ofs;
    endfunction

    function automatic ofs_t step_col_ofs(input logic [STEP_W-1:0] step);
        ofs_t ofs;
        unique case (step)
            4'd0, 4'd3, 4'd6: ofs = OFS_MINUS;
            4'd2, 4'd5, 4'd8: ofs = OFS_PLUS;
            default:          ofs = OFS_ZERO;
        endcase
        return ofs;
    endfunction

endpackage

FILE: rtl/gncf_ctrl.sv
module gncf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output gncf_pkg::dp_cmd_t    cmd,
    input  gncf_pkg::dp_status_t status
);
    import gncf_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.rd_step = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = (op_t'(in_op) == OP_EMIT) ? ST_SETUP : ST_SIZE;
                end
            end
            // A wait state for the grid area register to follow a new size.
            ST_SIZE:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = STEP_FIRST;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_DRAIN;
                else
                    step_next = step_reg + 4'd1;
            end
            ST_DRAIN:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> step_reg <= STEP_LAST)
        else $error("window step out of range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && in_valid |=> state_reg == ST_SIZE || state_reg == ST_SETUP)
        else $error("accepted word did not start work");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.load_write, cmd.setup, cmd.rd_en, cmd.finish}))
        else $error("more than one datapath command at once");

endmodule

FILE: rtl/gncf_dp.sv
module gncf_dp #(
    parameter int MAX_COLUMNS = gncf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gncf_pkg::DEF_MAX_ROWS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gncf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gncf_pkg::CFG_W-1:0]             cfg_data,
    input  logic signed [gncf_pkg::CELL_W-1:0]     cell_in,
    input  gncf_pkg::dp_cmd_t                      cmd,
    output gncf_pkg::dp_status_t                   status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [gncf_pkg::CELL_W-1:0]     cell_out,
    output logic [gncf_pkg::COUNT_W-1:0]           neighbour_count,
    output logic                                   was_cleared,
    output logic                                   last_cell
);
    import gncf_pkg::*;

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AREA_W = $clog2(DEPTH + 1);
    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CIDX_W = $clog2(MAX_COLUMNS);
    localparam int RIDX_W = $clog2(MAX_ROWS);

    // Configuration
    logic [CFG_W-1:0]  grid_width_reg;
    logic [CFG_W-1:0]  grid_height_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic [COL_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [AREA_W-1:0] area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RESET_GRID_DIM;
            grid_height_reg <= RESET_GRID_DIM;
            threshold_reg   <= RESET_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:     grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT:    grid_height_reg <= cfg_data;
                REG_PASS_THRESHOLD: threshold_reg   <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = COL_W'(1);
        else if (32'(grid_width_reg) > MAX_COLUMNS)
            eff_w = COL_W'(MAX_COLUMNS);
        else
            eff_w = COL_W'(grid_width_reg);

        if (grid_height_reg == '0)
            eff_h = ROW_W'(1);
        else if (32'(grid_height_reg) > MAX_ROWS)
            eff_h = ROW_W'(MAX_ROWS);
        else
            eff_h = ROW_W'(grid_height_reg);
    end

    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(eff_w) * AREA_W'(eff_h);
    end

    // Cell store
    logic [CELL_W-1:0]        mem [DEPTH];
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [CELL_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [CELL_W-1:0] rd_data_reg;

    // Load path
    logic signed [CELL_W-1:0] cell_in_reg;
    logic [ADDR_W-1:0]        load_pos_reg;
    logic [ADDR_W-1:0]        load_pos_next;
    logic [ADDR_W-1:0]        load_pos_eff;
    logic [AREA_W-1:0]        load_pos_inc;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            cell_in_reg <= cell_in;
    end

    always_comb
    begin
        load_pos_eff = (AREA_W'(load_pos_reg) >= area_reg) ? '0 : load_pos_reg;
        load_pos_inc = AREA_W'(load_pos_eff) + AREA_W'(1);
        load_pos_next = (load_pos_inc >= area_reg) ? '0 : ADDR_W'(load_pos_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_pos_reg <= '0;
        else if (cmd.load_write)
            load_pos_reg <= load_pos_next;
    end

    // Emit position and window setup
    logic [RIDX_W-1:0] emit_row_reg;
    logic [CIDX_W-1:0] emit_col_reg;
    logic [RIDX_W-1:0] emit_row_next;
    logic [CIDX_W-1:0] emit_col_next;
    logic [RIDX_W-1:0] row_fix;
    logic [CIDX_W-1:0] col_fix;
    logic [ROW_W-1:0]  row_inc;
    logic [COL_W-1:0]  col_inc;
    logic [ADDR_W-1:0] idx_reg;
    logic              top_reg;
    logic              bottom_reg;
    logic              left_reg;
    logic              right_reg;

    always_comb
    begin
        if ((ROW_W'(emit_row_reg) >= eff_h) || (COL_W'(emit_col_reg) >= eff_w))
        begin
            row_fix = '0;
            col_fix = '0;
        end
        else
        begin
            row_fix = emit_row_reg;
            col_fix = emit_col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            idx_reg    <= ADDR_W'(AREA_W'(row_fix) * AREA_W'(eff_w) + AREA_W'(col_fix));
            top_reg    <= (row_fix == '0);
            bottom_reg <= (ROW_W'(row_fix) == eff_h - ROW_W'(1));
            left_reg   <= (col_fix == '0);
            right_reg  <= (COL_W'(col_fix) == eff_w - COL_W'(1));
        end
    end

    always_comb
    begin
        row_inc       = ROW_W'(emit_row_reg) + ROW_W'(1);
        col_inc       = COL_W'(emit_col_reg) + COL_W'(1);
        emit_row_next = emit_row_reg;
        emit_col_next = CIDX_W'(col_inc);
        if (col_inc >= eff_w)
        begin
            emit_col_next = '0;
            emit_row_next = (row_inc >= eff_h) ? '0 : RIDX_W'(row_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end
        else if (cmd.setup)
        begin
            emit_row_reg <= row_fix;
            emit_col_reg <= col_fix;
        end
        else if (cmd.finish)
        begin
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
        end
    end

    // Window reads: one window address per cycle
    ofs_t              row_ofs;
    ofs_t              col_ofs;
    logic              nb_ok;
    logic [ADDR_W-1:0] row_delta;
    logic [ADDR_W-1:0] col_delta;

    always_comb
    begin
        row_ofs = step_row_ofs(cmd.rd_step);
        col_ofs = step_col_ofs(cmd.rd_step);
        nb_ok   = (cmd.rd_step != STEP_CENTER)
                  && !(row_ofs == OFS_MINUS && top_reg)
                  && !(row_ofs == OFS_PLUS  && bottom_reg)
                  && !(col_ofs == OFS_MINUS && left_reg)
                  && !(col_ofs == OFS_PLUS  && right_reg);
        unique case (row_ofs)
            OFS_MINUS: row_delta = ~ADDR_W'(eff_w) + ADDR_W'(1);
            OFS_PLUS:  row_delta = ADDR_W'(eff_w);
            default:   row_delta = '0;
        endcase
        unique case (col_ofs)
            OFS_MINUS: col_delta = '1;
            OFS_PLUS:  col_delta = ADDR_W'(1);
            default:   col_delta = '0;
        endcase
        rd_addr = nb_ok ? (idx_reg + row_delta + col_delta) : idx_reg;
    end

    logic rd_nb_reg;
    logic rd_center_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_nb_reg     <= 1'b0;
            rd_center_reg <= 1'b0;
        end
        else
        begin
            rd_nb_reg     <= cmd.rd_en && nb_ok;
            rd_center_reg <= cmd.rd_en && (cmd.rd_step == STEP_CENTER);
        end
    end

    // Tally of the window, taken from the registered read word
    logic                     unknown_reg;
    logic [COUNT_W-1:0]       occ_reg;
    logic signed [CELL_W-1:0] center_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            unknown_reg <= 1'b0;
            occ_reg     <= '0;
        end
        else if (rd_nb_reg)
        begin
            if (rd_data_reg == CELL_UNKNOWN)
                unknown_reg <= 1'b1;
            else if (rd_data_reg == CELL_OCCUPIED)
                occ_reg <= occ_reg + COUNT_W'(1);
        end
        if (rd_center_reg)
            center_reg <= rd_data_reg;
    end

    // Decision, write-back and output register
    logic [COUNT_W-1:0] count;
    logic               clear;
    logic               out_valid_reg;

    always_comb
    begin
        count     = unknown_reg ? COUNT_UNKNOWN : occ_reg;
        clear     = (count < threshold_reg);
        mem_we    = cmd.load_write || (cmd.finish && clear);
        mem_waddr = cmd.load_write ? load_pos_eff : idx_reg;
        mem_wdata = cmd.load_write ? cell_in_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            cell_out        <= clear ? '0 : center_reg;
            neighbour_count <= count;
            was_cleared     <= clear;
            last_cell       <= (AREA_W'(idx_reg) == area_reg - AREA_W'(1));
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while waiting");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> neighbour_count <= COUNT_MAX_OCC || neighbour_count == COUNT_UNKNOWN)
        else $error("neighbor count out of range");

    a_cleared_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && was_cleared |-> cell_out == '0)
        else $error("cleared cell is not zero");

endmodule

FILE: rtl/grid_neighbor_count_filter.sv
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: cell_in[7:0]; tuser: operation
// m_axis    out        tdata: cell_out[7:0], neighbour_count[11:8], was_cleared[12], zero pad
//                      tlast: last_cell
// cfg       in         cfg_index selects grid_width, grid_height, pass_threshold
//
// A load word passes through the size and load states; an emit word runs setup,
// nine window reads on the single read port of the cell store, drain and finish.
// rst_n clears the control state and the positions; the cell store holds
// nothing meaningful until loaded. The result register lets the next word be
// accepted while a result waits; an emit finishes only once that register is free.
module grid_neighbor_count_filter #(
    parameter int MAX_COLUMNS = gncf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gncf_pkg::DEF_MAX_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // cell_in
    input  logic                               s_axis_tuser,   // operation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // cell_out, count, cleared
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [gncf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gncf_pkg::CFG_W-1:0]         cfg_data
);
    import gncf_pkg::*;

    dp_cmd_t                  cmd;
    dp_status_t               status;
    logic signed [CELL_W-1:0] cell_out;
    logic [COUNT_W-1:0]       neighbour_count;
    logic                     was_cleared;

    gncf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    gncf_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cell_in         (s_axis_tdata),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .cell_out        (cell_out),
        .neighbour_count (neighbour_count),
        .was_cleared     (was_cleared),
        .last_cell       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, was_cleared, neighbour_count, cell_out};

endmodule

FILE: test/gncf_checker.sv
`timescale 1ns / 1ps

module gncf_checker #(
    parameter int MAX_COLUMNS = gncf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gncf_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // cell_in
    input  logic                             s_tuser,   // operation
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [15:0]                      m_tdata,   // cell_out, count, cleared, pad
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [gncf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gncf_pkg::CFG_W-1:0]       cfg_data,
    output int                               mismatches,
    output int                               awaiting,
    output int                               results_checked
);
    import gncf_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0]  level;
        logic [COUNT_W-1:0] count;
        logic               cleared;
        logic               last;
    } filtered_cell_t;

    logic [CELL_W-1:0] occupancy [MAX_COLUMNS*MAX_ROWS];
    filtered_cell_t    expected_cells [$];
    logic [CFG_W-1:0]  width_setting;
    logic [CFG_W-1:0]  height_setting;
    logic [THR_W-1:0]  clear_below;
    int                load_at;
    int                row_at;
    int                col_at;
    bit                wrong_field;

    function automatic int used_dim(input logic [CFG_W-1:0] value, input int limit);
        int result;
        if (value == 0)
            result = 1;
        else if (int'(value) > limit)
            result = limit;
        else
            result = int'(value);
        return result;
    endfunction

    // Any unknown neighbor overrides the occupied tally.
    function automatic int count_around(input int row, input int col, input int cols,
                                        input int rows);
        int occupied;
        bit unknown_seen;
        int nr;
        int nc;
        logic [CELL_W-1:0] v;
        occupied = 0;
        unknown_seen = 1'b0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = row + dr;
                nc = col + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols)
                begin
                    v = occupancy[nr*cols + nc];
                    if (v == CELL_UNKNOWN)
                        unknown_seen = 1'b1;
                    else if (v == CELL_OCCUPIED)
                        occupied++;
                end
            end
        end
        return unknown_seen ? int'(COUNT_UNKNOWN) : occupied;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns  %s: expected %0d, got %0d", $time, field, want, got);
            wrong_field = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        filtered_cell_t want;
        filtered_cell_t made;
        int cols;
        int rows;
        int idx;
        int count;
        if (!rst_n)
        begin
            width_setting   = RESET_GRID_DIM;
            height_setting  = RESET_GRID_DIM;
            clear_below     = RESET_THRESHOLD;
            load_at         = 0;
            row_at          = 0;
            col_at          = 0;
            expected_cells.delete();
            awaiting        = 0;
            mismatches      = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:     width_setting  = cfg_data;
                    REG_GRID_HEIGHT:    height_setting = cfg_data;
                    REG_PASS_THRESHOLD: clear_below    = cfg_data[THR_W-1:0];
                    default:            ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t ns  result word %h (last %b) with nothing expected",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    results_checked++;
                    wrong_field = 1'b0;
                    check_field("cell_out", int'($signed(want.level)),
                                int'($signed(m_tdata[7:0])));
                    check_field("neighbour_count", int'(want.count), int'(m_tdata[11:8]));
                    check_field("was_cleared", int'(want.cleared), int'(m_tdata[12]));
                    check_field("tdata pad", 0, int'(m_tdata[15:13]));
                    check_field("last_cell", int'(want.last), int'(m_tlast));
                    if (wrong_field)
                        mismatches++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                cols = used_dim(width_setting, MAX_COLUMNS);
                rows = used_dim(height_setting, MAX_ROWS);
                if (s_tuser == OP_LOAD)
                begin
                    if (load_at >= cols*rows)
                        load_at = 0;
                    occupancy[load_at] = s_tdata;
                    load_at++;
                    if (load_at >= cols*rows)
                        load_at = 0;
                end
                else
                begin
                    // A position left outside a shrunken grid restarts at the first cell.
                    if (row_at >= rows || col_at >= cols)
                    begin
                        row_at = 0;
                        col_at = 0;
                    end
                    idx = row_at*cols + col_at;
                    count = count_around(row_at, col_at, cols, rows);
                    made.cleared = (count < int'(clear_below));
                    if (made.cleared)
                        occupancy[idx] = '0;
                    made.level = occupancy[idx];
                    made.count = count[COUNT_W-1:0];
                    made.last  = (idx == cols*rows - 1);
                    expected_cells.push_back(made);
                    col_at++;
                    if (col_at >= cols)
                    begin
                        col_at = 0;
                        row_at++;
                        if (row_at >= rows)
                            row_at = 0;
                    end
                end
            end
            awaiting = expected_cells.size();
        end
    end

endmodule

FILE: test/grid_neighbor_count_filter_test.sv
`timescale 1ns / 1ps

module grid_neighbor_count_filter_test;
    import gncf_pkg::*;

    localparam int TOTAL_WORDS   = 1300;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 160;
    localparam int IDLE_LIMIT    = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [15:0]            m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int mismatches;
    int awaiting;
    int results_checked;

    bit calm;
    bit hold_request;
    bit hold_done;
    int loads_sent;
    int emits_sent;
    int settings_used;
    int written_span;
    int idle_count = 0;

    grid_neighbor_count_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gncf_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .m_tlast         (m_axis_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int used_dim(input int value, input int limit);
        int result;
        if (value == 0)
            result = 1;
        else if (value > limit)
            result = limit;
        else
            result = value;
        return result;
    endfunction

    function automatic int pick_dim();
        int r;
        int result;
        r = $urandom_range(0, 9);
        if (r == 0)
            result = 0;
        else if (r == 1)
            result = $urandom_range(13, 40);
        else
            result = $urandom_range(1, 10);
        return result;
    endfunction

    // Biased toward occupied, unknown and free cells so counts spread over the thresholds.
    function automatic logic [7:0] cell_value();
        int r;
        logic [7:0] v;
        r = $urandom_range(0, 19);
        if (r < 7)
            v = CELL_OCCUPIED;
        else if (r < 9)
            v = CELL_UNKNOWN;
        else if (r < 14)
            v = 8'd0;
        else if (r < 17)
            v = 8'($urandom_range(1, 99));
        else
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic send_word(input op_t op, input logic [7:0] value);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        if (op == OP_LOAD)
            loads_sent++;
        else
            emits_sent++;
        calm = (loads_sent + emits_sent) >= TOTAL_WORDS - CALM_TAIL;
    endtask

    // Stop offering words and let every outstanding result drain, plus the tail
    // of any load still in flight.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (awaiting == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup_grid(input int w, input int h, input int thr);
        settle();
        write_reg(REG_GRID_WIDTH, w[CFG_W-1:0]);
        write_reg(REG_GRID_HEIGHT, h[CFG_W-1:0]);
        write_reg(REG_PASS_THRESHOLD, thr[CFG_W-1:0]);
        settings_used++;
    endtask

    // A full run of loads covers every cell of the grid, wherever the load position starts.
    task automatic fill_grid(input int area);
        repeat (area) send_word(OP_LOAD, cell_value());
        if (area > written_span)
            written_span = area;
    endtask

    task automatic mixed_words(input int n, input int emit_pct);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < emit_pct)
                send_word(OP_EMIT, 8'($urandom_range(0, 255)));
            else
                send_word(OP_LOAD, cell_value());
        end
    endtask

    initial
    begin : receiver
        int burst;
        burst = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                // Long back-pressure so the block fills and stalls its input.
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (burst > 0)
            begin
                m_axis_tready <= 1'b0;
                burst--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(0, 2);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("%0t ns  timeout: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0] corner_pattern [9];
        int w;
        int h;
        int area;
        int phase;
        int n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        cfg_we        = 1'b0;
        cfg_index     = REG_GRID_WIDTH;
        cfg_data      = '0;
        calm          = 1'b0;
        hold_request  = 1'b0;
        loads_sent    = 0;
        emits_sent    = 0;
        settings_used = 0;
        written_span  = 0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 grid: full occupied corner, odd values, the most negative byte and an
        // unknown corner; ten emits so the last one wraps back to the first cell.
        corner_pattern = '{CELL_OCCUPIED, CELL_OCCUPIED, CELL_OCCUPIED,
                           CELL_OCCUPIED, 8'd7,          8'h80,
                           8'd101,        8'd99,         CELL_UNKNOWN};
        setup_grid(3, 3, 4);
        foreach (corner_pattern[i])
            send_word(OP_LOAD, corner_pattern[i]);
        written_span = 9;
        repeat (10) send_word(OP_EMIT, 8'hA5);

        // Degenerate and saturated sizes with the threshold extremes.
        setup_grid(0, 0, 0);
        fill_grid(1);
        mixed_words(8, 70);
        setup_grid(9'h1FF, 1, 15);
        fill_grid(256);
        mixed_words(40, 80);
        setup_grid(0, 9'h1FF, 10);
        fill_grid(256);
        mixed_words(40, 80);

        phase = 0;
        while (loads_sent + emits_sent < TOTAL_WORDS)
        begin
            w = pick_dim();
            h = pick_dim();
            if (used_dim(w, DEF_MAX_COLUMNS) * used_dim(h, DEF_MAX_ROWS) > 200)
                h = $urandom_range(1, 4);
            area = used_dim(w, DEF_MAX_COLUMNS) * used_dim(h, DEF_MAX_ROWS);
            setup_grid(w, h, $urandom_range(0, 15));
            // Shrinking may keep the old contents; growing past the written span always reloads.
            if (area > written_span || $urandom_range(0, 2) == 0)
                fill_grid(area);
            if (phase == 1)
            begin
                hold_request = 1'b1;
                mixed_words(30, 100);
            end
            else
            begin
                n = $urandom_range(area/2 + 4, 2*area + 8);
                if (n > 60)
                    n = 60;
                mixed_words(n, 65);
            end
            phase++;
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (awaiting == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d loads and %0d emits over %0d grid settings,", loads_sent,
                 emits_sent, settings_used);
        $display("from 1x1 to 256-cell grids, thresholds 0..15; %0d filtered cells compared.",
                 results_checked);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
